// ----- hdl/digital_clock_with_button_setup_macros.svh -----
// assertion macros for the digital clock block
`ifndef DIGITAL_CLOCK_WITH_BUTTON_SETUP_MACROS_SVH
`define DIGITAL_CLOCK_WITH_BUTTON_SETUP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DCLK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DCLK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dclk_pkg.sv -----
// types, constants and helper functions for the digital clock block
package dclk_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [11:0] DEBOUNCE_RESET = 12'd20;
  localparam logic [11:0] HOLD_RESET     = 12'd300;
  localparam logic [11:0] REPEAT_RESET   = 12'd66;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_REPEAT   = 2'd2;

  localparam logic [2:0] BTN_NONE  = 3'b000;
  localparam logic [2:0] BTN_SETUP = 3'b001;
  localparam logic [2:0] BTN_PLUS  = 3'b010;
  localparam logic [2:0] BTN_MINUS = 3'b100;

  localparam logic [5:0] SEC_LIMIT  = 6'd60;
  localparam logic [5:0] MIN_LIMIT  = 6'd60;
  localparam logic [5:0] HOUR_LIMIT = 6'd24;

  typedef enum logic [2:0] {
    PS_IDLE     = 3'd0,
    PS_DEBOUNCE = 3'd1,
    PS_SINGLE   = 3'd2,
    PS_HOLD     = 3'd3,
    PS_WAIT     = 3'd4
  } press_state_t;

  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_SETUP = 2'd1,
    SEL_PLUS  = 2'd2,
    SEL_MINUS = 2'd3
  } sel_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_HOLD   = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_SEC  = 2'd1,
    MODE_MIN  = 2'd2,
    MODE_HOUR = 2'd3
  } mode_t;

  typedef struct packed {
    logic [11:0] debounce_ms;
    logic [11:0] hold_ms;
    logic [11:0] repeat_ms;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic second_tick;
    ev_t  ev;
    sel_t sel;
  } q_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [5:0] unit_inc(input logic [5:0] v, input logic [5:0] lim);
    logic [5:0] s;
    s = v + 6'd1;
    return (s >= lim) ? 6'd0 : s;
  endfunction

  function automatic logic [5:0] unit_dec(input logic [5:0] v, input logic [5:0] lim);
    return (v == 6'd0 || v > lim) ? lim - 6'd1 : v - 6'd1;
  endfunction

  function automatic mode_t next_mode(input mode_t m);
    case (m)
      MODE_RUN:  return MODE_SEC;
      MODE_SEC:  return MODE_MIN;
      MODE_MIN:  return MODE_HOUR;
      MODE_HOUR: return MODE_RUN;
      default:   return MODE_RUN;
    endcase
  endfunction

endpackage

// ----- hdl/dclk_poll_if.sv -----
// input channel: button reading and tick flags
interface dclk_poll_if;
  logic       valid;
  logic       ready;
  logic [2:0] buttons;
  logic       ms_tick;
  logic       second_tick;

  modport source(output valid, output buttons, output ms_tick, output second_tick,
                 input ready);
  modport sink(input valid, input buttons, input ms_tick, input second_tick,
               output ready);
endinterface

// ----- hdl/dclk_status_if.sv -----
// output channel: time of day, mode and press event
interface dclk_status_if;
  logic       valid;
  logic       ready;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic [1:0] mode;
  logic [1:0] press_event;

  modport source(output valid, output hours, output minutes, output seconds,
                 output mode, output press_event, input ready);
  modport sink(input valid, input hours, input minutes, input seconds,
               input mode, input press_event, output ready);
endinterface

// ----- hdl/dclk_front.sv -----
// front end: millisecond count and button qualifier, classifies each item
module dclk_front (
  input  logic               clk,
  input  logic               rst,
  input  dclk_pkg::cfg_t     cfg,
  input  dclk_pkg::q_stat_t  q_stat,
  dclk_poll_if.sink          poll,
  output logic               push,
  output dclk_pkg::q_item_t  item
);

  dclk_pkg::press_state_t press_state, press_state_next;
  dclk_pkg::press_state_t prior_press_state, prior_press_state_next;
  logic [2:0]             held_reading, held_reading_next;
  dclk_pkg::sel_t         selected_button, selected_button_next;
  logic [15:0]            ms_now, ms_now_next;
  logic [15:0]            press_time, press_time_next;

  logic        same;
  logic [15:0] elapsed;
  logic        deb_done, hold_done, rpt_done;
  logic        go_idle;
  dclk_pkg::sel_t rd_sel;

  assign poll.ready = !q_stat.full;
  assign push       = poll.valid && poll.ready;

  assign ms_now_next = poll.ms_tick ? ms_now + 16'd1 : ms_now;
  assign same        = (poll.buttons == held_reading) &&
                       (selected_button != dclk_pkg::SEL_NONE);
  assign elapsed     = ms_now_next - press_time;
  assign deb_done    = elapsed > {4'd0, cfg.debounce_ms};
  assign hold_done   = elapsed > {4'd0, cfg.hold_ms};
  assign rpt_done    = elapsed > {4'd0, cfg.repeat_ms};

  always_comb begin
    case (poll.buttons)
      dclk_pkg::BTN_SETUP: rd_sel = dclk_pkg::SEL_SETUP;
      dclk_pkg::BTN_PLUS:  rd_sel = dclk_pkg::SEL_PLUS;
      dclk_pkg::BTN_MINUS: rd_sel = dclk_pkg::SEL_MINUS;
      default:             rd_sel = dclk_pkg::SEL_NONE;
    endcase
  end

  // next state of the qualifier
  always_comb begin
    press_state_next       = press_state;
    prior_press_state_next = prior_press_state;
    go_idle                = 1'b0;
    case (press_state)
      dclk_pkg::PS_IDLE: begin
        if (poll.buttons != dclk_pkg::BTN_NONE) begin
          press_state_next = dclk_pkg::PS_DEBOUNCE;
        end
      end
      dclk_pkg::PS_DEBOUNCE: begin
        if (same) begin
          press_state_next       = dclk_pkg::PS_WAIT;
          prior_press_state_next = dclk_pkg::PS_DEBOUNCE;
        end else begin
          go_idle = 1'b1;
        end
      end
      dclk_pkg::PS_SINGLE, dclk_pkg::PS_HOLD: begin
        if (same) begin
          press_state_next       = dclk_pkg::PS_WAIT;
          prior_press_state_next = press_state;
        end else begin
          go_idle = 1'b1;
        end
      end
      dclk_pkg::PS_WAIT: begin
        if (!same) begin
          go_idle                = 1'b1;
          prior_press_state_next = dclk_pkg::PS_WAIT;
        end else if (prior_press_state == dclk_pkg::PS_DEBOUNCE && deb_done) begin
          press_state_next       = dclk_pkg::PS_SINGLE;
          prior_press_state_next = dclk_pkg::PS_WAIT;
        end else if (prior_press_state == dclk_pkg::PS_SINGLE && hold_done) begin
          press_state_next       = dclk_pkg::PS_HOLD;
          prior_press_state_next = dclk_pkg::PS_WAIT;
        end else if (prior_press_state == dclk_pkg::PS_HOLD && rpt_done) begin
          press_state_next       = dclk_pkg::PS_HOLD;
          prior_press_state_next = dclk_pkg::PS_WAIT;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase
    if (go_idle) begin
      press_state_next = dclk_pkg::PS_IDLE;
    end
  end

  // press bookkeeping
  always_comb begin
    held_reading_next    = held_reading;
    selected_button_next = selected_button;
    press_time_next      = press_time;
    if (go_idle) begin
      held_reading_next    = dclk_pkg::BTN_NONE;
      selected_button_next = dclk_pkg::SEL_NONE;
      press_time_next      = 16'd0;
    end else if (press_state == dclk_pkg::PS_IDLE &&
                 poll.buttons != dclk_pkg::BTN_NONE) begin
      held_reading_next    = poll.buttons;
      selected_button_next = rd_sel;
      press_time_next      = ms_now_next;
    end else if ((press_state == dclk_pkg::PS_SINGLE ||
                  press_state == dclk_pkg::PS_HOLD) && same) begin
      press_time_next = ms_now_next;
    end
  end

  // classified item for the back end
  always_comb begin
    item.second_tick = poll.second_tick;
    item.sel         = selected_button_next;
    case (press_state_next)
      dclk_pkg::PS_SINGLE: item.ev = dclk_pkg::EV_SINGLE;
      dclk_pkg::PS_HOLD:   item.ev = dclk_pkg::EV_HOLD;
      default:             item.ev = dclk_pkg::EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_state       <= dclk_pkg::PS_IDLE;
      prior_press_state <= dclk_pkg::PS_IDLE;
      held_reading      <= dclk_pkg::BTN_NONE;
      selected_button   <= dclk_pkg::SEL_NONE;
      ms_now            <= 16'd0;
      press_time        <= 16'd0;
    end else if (push) begin
      press_state       <= press_state_next;
      prior_press_state <= prior_press_state_next;
      held_reading      <= held_reading_next;
      selected_button   <= selected_button_next;
      ms_now            <= ms_now_next;
      press_time        <= press_time_next;
    end
  end

endmodule

// ----- hdl/dclk_queue.sv -----
// short queue of classified items between front and back
module dclk_queue #(
  parameter int DEPTH = dclk_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dclk_pkg::q_item_t  push_item,
  input  logic               pop,
  output dclk_pkg::q_item_t  head,
  output dclk_pkg::q_stat_t  stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  dclk_pkg::q_item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == FULL_COUNT);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/dclk_back.sv -----
// back end: time counters, set mode and adjustment, result register
module dclk_back (
  input  logic               clk,
  input  logic               rst,
  input  dclk_pkg::q_item_t  head,
  input  dclk_pkg::q_stat_t  q_stat,
  output logic               pop,
  dclk_status_if.source      status
);

  logic [4:0]     hour_count, hour_count_next;
  logic [5:0]     minute_count, minute_count_next;
  logic [5:0]     second_count, second_count_next;
  dclk_pkg::mode_t set_mode, set_mode_next;
  dclk_pkg::ev_t  press_event;
  logic           out_valid;

  logic [5:0] sec_t, min_t, hour_t;
  logic       adj_up, adj_dn;

  assign pop = !q_stat.empty && (!out_valid || status.ready);

  // second tick with carry
  always_comb begin
    sec_t  = second_count;
    min_t  = minute_count;
    hour_t = {1'b0, hour_count};
    if (head.second_tick) begin
      sec_t = dclk_pkg::unit_inc(second_count, dclk_pkg::SEC_LIMIT);
      if (sec_t == 6'd0) begin
        min_t = dclk_pkg::unit_inc(minute_count, dclk_pkg::MIN_LIMIT);
        if (min_t == 6'd0) begin
          hour_t = dclk_pkg::unit_inc({1'b0, hour_count}, dclk_pkg::HOUR_LIMIT);
        end
      end
    end
  end

  // mode step and unit adjustment
  always_comb begin
    second_count_next = sec_t;
    minute_count_next = min_t;
    hour_count_next   = hour_t[4:0];
    set_mode_next     = set_mode;
    adj_up = 1'b0;
    adj_dn = 1'b0;
    if (head.sel == dclk_pkg::SEL_SETUP && head.ev == dclk_pkg::EV_SINGLE) begin
      set_mode_next = dclk_pkg::next_mode(set_mode);
    end else if (set_mode != dclk_pkg::MODE_RUN && head.ev != dclk_pkg::EV_NONE) begin
      adj_up = (head.sel == dclk_pkg::SEL_PLUS);
      adj_dn = (head.sel == dclk_pkg::SEL_MINUS);
    end
    if (adj_up || adj_dn) begin
      case (set_mode)
        dclk_pkg::MODE_SEC: begin
          second_count_next = adj_up ? dclk_pkg::unit_inc(sec_t, dclk_pkg::SEC_LIMIT)
                                     : dclk_pkg::unit_dec(sec_t, dclk_pkg::SEC_LIMIT);
        end
        dclk_pkg::MODE_MIN: begin
          minute_count_next = adj_up ? dclk_pkg::unit_inc(min_t, dclk_pkg::MIN_LIMIT)
                                     : dclk_pkg::unit_dec(min_t, dclk_pkg::MIN_LIMIT);
        end
        dclk_pkg::MODE_HOUR: begin
          hour_count_next = adj_up
              ? 5'(dclk_pkg::unit_inc(hour_t, dclk_pkg::HOUR_LIMIT))
              : 5'(dclk_pkg::unit_dec(hour_t, dclk_pkg::HOUR_LIMIT));
        end
        default: begin
          second_count_next = sec_t;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count   <= 5'd0;
      minute_count <= 6'd0;
      second_count <= 6'd0;
      set_mode     <= dclk_pkg::MODE_RUN;
      press_event  <= dclk_pkg::EV_NONE;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        hour_count   <= hour_count_next;
        minute_count <= minute_count_next;
        second_count <= second_count_next;
        set_mode     <= set_mode_next;
        press_event  <= head.ev;
        out_valid    <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.valid       = out_valid;
  assign status.hours       = hour_count;
  assign status.minutes     = minute_count;
  assign status.seconds     = second_count;
  assign status.mode        = set_mode;
  assign status.press_event = press_event;

endmodule

// ----- hdl/digital_clock_with_button_setup.sv -----
// top level of the digital clock with debounced set buttons
//
//  channel   dir  handshake          payload
//  poll      in   valid/ready        buttons[2:0], ms_tick, second_tick
//  status    out  valid/ready        hours, minutes, seconds, mode, press_event
//  apb       in   psel/penable       paddr[3:0], pwdata[31:0], prdata[31:0]
//
//  one item per cycle unless status stalls; each item passes the queue, then the
//  result register; the front qualifier updates in the accept cycle, the back
//  counters when the item dequeues; the queue holds QUEUE_DEPTH classified items
//  a stalled status fills the queue, then poll.ready drops until status drains
//  synchronous reset clears the clock, mode, qualifier and queue; registers return
//  to 20, 300 and 66 ms
module digital_clock_with_button_setup #(
  parameter int QUEUE_DEPTH = dclk_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  dclk_poll_if.sink   poll,
  dclk_status_if.source status
);

`include "digital_clock_with_button_setup_macros.svh"

  // configuration registers
  dclk_pkg::cfg_t cfg;
  logic           cfg_write;
  logic [1:0]     reg_index;

  // front to queue to back
  logic              push, pop;
  dclk_pkg::q_item_t push_item, head;
  dclk_pkg::q_stat_t q_stat;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= dclk_pkg::DEBOUNCE_RESET;
      cfg.hold_ms     <= dclk_pkg::HOLD_RESET;
      cfg.repeat_ms   <= dclk_pkg::REPEAT_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        dclk_pkg::REG_DEBOUNCE: cfg.debounce_ms <= pwdata[11:0];
        dclk_pkg::REG_HOLD:     cfg.hold_ms     <= pwdata[11:0];
        dclk_pkg::REG_REPEAT:   cfg.repeat_ms   <= pwdata[11:0];
        default:                cfg.repeat_ms   <= cfg.repeat_ms;
      endcase
    end
  end

  // register readback, unmapped slot reads zero
  always_comb begin
    case (reg_index)
      dclk_pkg::REG_DEBOUNCE: prdata = {20'd0, cfg.debounce_ms};
      dclk_pkg::REG_HOLD:     prdata = {20'd0, cfg.hold_ms};
      dclk_pkg::REG_REPEAT:   prdata = {20'd0, cfg.repeat_ms};
      default:                prdata = 32'd0;
    endcase
  end

  // front: ms counter and button qualifier
  dclk_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_stat (q_stat),
    .poll   (poll),
    .push   (push),
    .item   (push_item)
  );

  // decoupling queue
  dclk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // back: time of day, mode, result register
  dclk_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .status (status)
  );

  // a waiting queue entry with a free result register is delivered next cycle
  `DCLK_ASSERT_NEXT(a_drain, clk, rst, !q_stat.empty && (!status.valid || status.ready), status.valid, "queued item not moved to result")

  // a stalled result with a full queue blocks the next accept
  `DCLK_ASSERT_NEXT(a_backpressure, clk, rst, status.valid && !status.ready && q_stat.full, !poll.ready, "accept while queue full")

  // second rollover while running
  `DCLK_ASSERT_NEXT(a_rollover, clk, rst, pop && head.second_tick && status.seconds == 6'd59 && status.mode == dclk_pkg::MODE_RUN, status.seconds == 6'd0, "seconds did not wrap")

  // nothing leaves an empty queue
  `DCLK_ASSERT_NOW(a_no_underflow, clk, rst, q_stat.empty, !pop, "pop from empty queue")

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the digital clock with debounced set buttons
`timescale 1ns / 100ps

module testbench;

  // time of day, mode and press event as seen on the status channel
  typedef struct packed {
    logic [4:0]      hours;
    logic [5:0]      minutes;
    logic [5:0]      seconds;
    dclk_pkg::mode_t mode;
    dclk_pkg::ev_t   press_event;
  } clock_status_t;

  // one row of the directed button script
  typedef struct packed {
    logic [2:0]    buttons;
    logic          ms_tick;
    logic          second_tick;
    bit            typed;
    clock_status_t want;
  } script_row_t;

  // index with no register behind it, writes there must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // every button at once
  localparam logic [2:0] BTN_ALL = dclk_pkg::BTN_SETUP | dclk_pkg::BTN_PLUS |
                                   dclk_pkg::BTN_MINUS;

  // directed script, run with all three intervals at zero so that a press
  // qualifies after a single millisecond; only the first rows carry a typed
  // expectation, the rest go through the predictor
  localparam script_row_t BUTTON_SCRIPT [0:23] = '{
    // quiet item straight after reset
    '{dclk_pkg::BTN_NONE, 1'b0, 1'b0, 1'b1,
      '{5'd0, 6'd0, 6'd0, dclk_pkg::MODE_RUN, dclk_pkg::EV_NONE}},
    // second tick while running
    '{dclk_pkg::BTN_NONE, 1'b0, 1'b1, 1'b1,
      '{5'd0, 6'd0, 6'd1, dclk_pkg::MODE_RUN, dclk_pkg::EV_NONE}},
    // multi-button reading starts a debounce with no button selected
    '{BTN_ALL, 1'b1, 1'b0, 1'b1,
      '{5'd0, 6'd0, 6'd1, dclk_pkg::MODE_RUN, dclk_pkg::EV_NONE}},
    // and drops straight back to not pressed
    '{BTN_ALL, 1'b1, 1'b0, 1'b1,
      '{5'd0, 6'd0, 6'd1, dclk_pkg::MODE_RUN, dclk_pkg::EV_NONE}},
    // plus while running: single press then hold, time left alone
    '{dclk_pkg::BTN_PLUS,  1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_PLUS,  1'b0, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_PLUS,  1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_PLUS,  1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_PLUS,  1'b1, 1'b0, 1'b0, '0},
    // release out of hold
    '{dclk_pkg::BTN_NONE,  1'b0, 1'b0, 1'b0, '0},
    // setup press enters set seconds
    '{dclk_pkg::BTN_SETUP, 1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_SETUP, 1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_SETUP, 1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_NONE,  1'b0, 1'b0, 1'b0, '0},
    // minus: single press, hold wraps seconds below zero, repeat
    '{dclk_pkg::BTN_MINUS, 1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_MINUS, 1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_MINUS, 1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_MINUS, 1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_MINUS, 1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_MINUS, 1'b1, 1'b0, 1'b0, '0},
    // second tick in set mode carries into minutes, same item repeats minus
    '{dclk_pkg::BTN_MINUS, 1'b1, 1'b1, 1'b0, '0},
    // change of button during a hold
    '{dclk_pkg::BTN_PLUS,  1'b1, 1'b0, 1'b0, '0},
    '{dclk_pkg::BTN_PLUS,  1'b1, 1'b0, 1'b0, '0},
    // different reading during debounce
    '{dclk_pkg::BTN_SETUP, 1'b1, 1'b0, 1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dclk_poll_if   poll();
  dclk_status_if status();

  digital_clock_with_button_setup i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .poll    (poll),
    .status  (status)
  );

  // predicted clock state, mirrors the block after each accepted item
  dclk_pkg::cfg_t         interval_cfg  = '{dclk_pkg::DEBOUNCE_RESET, dclk_pkg::HOLD_RESET,
                                            dclk_pkg::REPEAT_RESET};
  logic [5:0]             hour_now      = '0;
  logic [5:0]             minute_now    = '0;
  logic [5:0]             second_now    = '0;
  dclk_pkg::mode_t        run_mode      = dclk_pkg::MODE_RUN;
  dclk_pkg::press_state_t press_st      = dclk_pkg::PS_IDLE;
  dclk_pkg::press_state_t press_prev    = dclk_pkg::PS_IDLE;
  logic [2:0]             held_buttons  = '0;
  dclk_pkg::sel_t         pressed       = dclk_pkg::SEL_NONE;
  logic [15:0]            ms_count      = '0;
  logic [15:0]            press_start   = '0;

  // status items still owed by the block, oldest first
  clock_status_t expected_status [$];
  clock_status_t oldest_status;
  int          mismatches  = 0;
  int          polls_sent  = 0;
  bit          idle_on     = 1'b1;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // count up within a unit, wrap to zero at the limit
  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] lim);
    return (int'(v) + 1 >= int'(lim)) ? 6'd0 : v + 6'd1;
  endfunction

  // count down within a unit, wrap to the top below zero
  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] lim);
    return (v == 6'd0 || v > lim) ? lim - 6'd1 : v - 6'd1;
  endfunction

  // drop the press and forget the button
  function automatic void release_press();
    press_st     = dclk_pkg::PS_IDLE;
    press_start  = '0;
    held_buttons = '0;
    pressed      = dclk_pkg::SEL_NONE;
  endfunction

  // apply one poll item and return the status it should produce
  function automatic clock_status_t advance_clock(input logic [2:0] rd, input logic ms,
                                                  input logic sec);
    logic          same;
    logic [15:0]   elapsed;
    dclk_pkg::ev_t ev;
    clock_status_t r;

    // millisecond counter first, then the second tick with carry
    if (ms)
      ms_count = ms_count + 16'd1;
    if (sec) begin
      second_now = wrap_up(second_now, dclk_pkg::SEC_LIMIT);
      if (second_now == 6'd0) begin
        minute_now = wrap_up(minute_now, dclk_pkg::MIN_LIMIT);
        if (minute_now == 6'd0)
          hour_now = wrap_up(hour_now, dclk_pkg::HOUR_LIMIT);
      end
    end

    // button qualifier; elapsed time wraps at 16 bits
    same    = (rd == held_buttons) && (pressed != dclk_pkg::SEL_NONE);
    elapsed = ms_count - press_start;
    case (press_st)
      dclk_pkg::PS_IDLE: begin
        if (rd != dclk_pkg::BTN_NONE) begin
          press_start  = ms_count;
          held_buttons = rd;
          case (rd)
            dclk_pkg::BTN_SETUP: pressed = dclk_pkg::SEL_SETUP;
            dclk_pkg::BTN_PLUS:  pressed = dclk_pkg::SEL_PLUS;
            dclk_pkg::BTN_MINUS: pressed = dclk_pkg::SEL_MINUS;
            default:             pressed = dclk_pkg::SEL_NONE;
          endcase
          press_st = dclk_pkg::PS_DEBOUNCE;
        end
      end
      dclk_pkg::PS_DEBOUNCE: begin
        if (same) begin
          press_st   = dclk_pkg::PS_WAIT;
          press_prev = dclk_pkg::PS_DEBOUNCE;
        end else begin
          release_press();
        end
      end
      dclk_pkg::PS_SINGLE, dclk_pkg::PS_HOLD: begin
        if (same) begin
          press_prev  = press_st;
          press_st    = dclk_pkg::PS_WAIT;
          press_start = ms_count;
        end else begin
          release_press();
        end
      end
      dclk_pkg::PS_WAIT: begin
        if (!same) begin
          release_press();
          press_prev = dclk_pkg::PS_WAIT;
        end else if (press_prev == dclk_pkg::PS_DEBOUNCE) begin
          if (elapsed > interval_cfg.debounce_ms) begin
            press_st   = dclk_pkg::PS_SINGLE;
            press_prev = dclk_pkg::PS_WAIT;
          end
        end else if (press_prev == dclk_pkg::PS_SINGLE) begin
          if (elapsed > interval_cfg.hold_ms) begin
            press_st   = dclk_pkg::PS_HOLD;
            press_prev = dclk_pkg::PS_WAIT;
          end
        end else if (press_prev == dclk_pkg::PS_HOLD) begin
          if (elapsed > interval_cfg.repeat_ms) begin
            press_st   = dclk_pkg::PS_HOLD;
            press_prev = dclk_pkg::PS_WAIT;
          end
        end
      end
      default: release_press();
    endcase

    if (press_st == dclk_pkg::PS_SINGLE)
      ev = dclk_pkg::EV_SINGLE;
    else if (press_st == dclk_pkg::PS_HOLD)
      ev = dclk_pkg::EV_HOLD;
    else
      ev = dclk_pkg::EV_NONE;

    // setup steps the mode, plus and minus trim the selected unit
    if (pressed == dclk_pkg::SEL_SETUP && press_st == dclk_pkg::PS_SINGLE) begin
      run_mode = dclk_pkg::mode_t'(run_mode + 2'd1);
    end else if (run_mode != dclk_pkg::MODE_RUN && ev != dclk_pkg::EV_NONE &&
                 (pressed == dclk_pkg::SEL_PLUS || pressed == dclk_pkg::SEL_MINUS)) begin
      case (run_mode)
        dclk_pkg::MODE_SEC:
          second_now = (pressed == dclk_pkg::SEL_PLUS)
                       ? wrap_up(second_now, dclk_pkg::SEC_LIMIT)
                       : wrap_down(second_now, dclk_pkg::SEC_LIMIT);
        dclk_pkg::MODE_MIN:
          minute_now = (pressed == dclk_pkg::SEL_PLUS)
                       ? wrap_up(minute_now, dclk_pkg::MIN_LIMIT)
                       : wrap_down(minute_now, dclk_pkg::MIN_LIMIT);
        dclk_pkg::MODE_HOUR:
          hour_now   = (pressed == dclk_pkg::SEL_PLUS)
                       ? wrap_up(hour_now, dclk_pkg::HOUR_LIMIT)
                       : wrap_down(hour_now, dclk_pkg::HOUR_LIMIT);
        default: ;
      endcase
    end

    r.hours       = hour_now[4:0];
    r.minutes     = minute_now;
    r.seconds     = second_now;
    r.mode        = run_mode;
    r.press_event = ev;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------

  // setup then access cycle; the shadow copy follows the write
  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      dclk_pkg::REG_DEBOUNCE: interval_cfg.debounce_ms = val[11:0];
      dclk_pkg::REG_HOLD:     interval_cfg.hold_ms     = val[11:0];
      dclk_pkg::REG_REPEAT:   interval_cfg.repeat_ms   = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // read back all three intervals against the shadow copy
  task automatic check_registers();
    logic [11:0] want;
    for (int i = int'(dclk_pkg::REG_DEBOUNCE); i <= int'(dclk_pkg::REG_REPEAT); i++) begin
      case (2'(i))
        dclk_pkg::REG_DEBOUNCE: want = interval_cfg.debounce_ms;
        dclk_pkg::REG_HOLD:     want = interval_cfg.hold_ms;
        default:                want = interval_cfg.repeat_ms;
      endcase
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {2'(i), 2'b00};
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata !== {20'd0, want}) begin
        mismatches++;
        $display("%0t ns: register %0d expected %0d, got %0d", $time, i, want, prdata);
      end
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // poll side
  // ---------------------------------------------------------------------

  // offer one item, called at a falling edge, returns at a falling edge;
  // the expectation is queued at the edge that takes the item
  task automatic send_item(input logic [2:0] b, input logic ms, input logic sec,
                           input bit typed, input clock_status_t want);
    clock_status_t predicted;
    // random idle burst ahead of the item
    if (idle_on && $urandom_range(0, 3) == 0) begin
      poll.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    poll.valid       <= 1'b1;
    poll.buttons     <= b;
    poll.ms_tick     <= ms;
    poll.second_tick <= sec;
    @(posedge clk);
    while (!poll.ready) @(posedge clk);
    predicted = advance_clock(b, ms, sec);
    expected_status.push_back(typed ? want : predicted);
    polls_sent++;
    @(negedge clk);
  endtask

  // mostly well-formed presses of random length and tick density,
  // some glitches inside a press and some bursts of pure noise
  task automatic random_traffic(input int n_items);
    int         stop_at;
    int         len;
    int         ms_pct;
    logic [2:0] rd;
    logic [2:0] b;
    stop_at = polls_sent + n_items;
    while (polls_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 9))
          0, 1, 2: rd = dclk_pkg::BTN_SETUP;
          3, 4, 5: rd = dclk_pkg::BTN_PLUS;
          6, 7, 8: rd = dclk_pkg::BTN_MINUS;
          default: rd = 3'($urandom_range(3, 7));
        endcase
        len    = $urandom_range(1, 40);
        ms_pct = $urandom_range(25, 100);
        repeat (len) begin
          b = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(0, 7)) : rd;
          send_item(b, $urandom_range(1, 100) <= ms_pct, $urandom_range(0, 4) == 0,
                    1'b0, '0);
        end
        // release
        repeat ($urandom_range(1, 3))
          send_item(dclk_pkg::BTN_NONE, 1'($urandom_range(0, 1)),
                    $urandom_range(0, 4) == 0, 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 10))
          send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end
  endtask

  // every item yields one status item, so an empty queue means idle
  task automatic wait_drained();
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // status side
  // ---------------------------------------------------------------------

  // ready toggles in bursts, steady high once idling is switched off
  initial begin
    status.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        status.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      status.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // compare each taken status item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && status.valid && status.ready) begin
      if (expected_status.size() == 0) begin
        mismatches++;
        $display("%0t ns: status item with nothing expected", $time);
      end else begin
        oldest_status = expected_status.pop_front();
        report_field("hours", oldest_status.hours, status.hours);
        report_field("minutes", oldest_status.minutes, status.minutes);
        report_field("seconds", oldest_status.seconds, status.seconds);
        report_field("mode", oldest_status.mode, status.mode);
        report_field("press_event", oldest_status.press_event, status.press_event);
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    poll.valid       = 1'b0;
    poll.buttons     = dclk_pkg::BTN_NONE;
    poll.ms_tick     = 1'b0;
    poll.second_tick = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers must come out of reset at their defaults
    check_registers();

    // directed script with every interval at its low extreme
    set_reg(dclk_pkg::REG_DEBOUNCE, 32'd0);
    set_reg(dclk_pkg::REG_HOLD, 32'd0);
    set_reg(dclk_pkg::REG_REPEAT, 32'd0);
    check_registers();
    for (int i = 0; i < $size(BUTTON_SCRIPT); i++)
      send_item(BUTTON_SCRIPT[i].buttons, BUTTON_SCRIPT[i].ms_tick,
                BUTTON_SCRIPT[i].second_tick, BUTTON_SCRIPT[i].typed,
                BUTTON_SCRIPT[i].want);
    poll.valid <= 1'b0;
    wait_drained();

    // random phases, each under its own interval setting; past the first, upper
    // data bits are random so the 12-bit masking is exercised
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          // reset defaults written back explicitly
          set_reg(dclk_pkg::REG_DEBOUNCE, 32'(dclk_pkg::DEBOUNCE_RESET));
          set_reg(dclk_pkg::REG_HOLD, 32'(dclk_pkg::HOLD_RESET));
          set_reg(dclk_pkg::REG_REPEAT, 32'(dclk_pkg::REPEAT_RESET));
        end
        1: begin
          // fully random values, plus a write to the empty slot
          set_reg(dclk_pkg::REG_DEBOUNCE, $urandom());
          set_reg(dclk_pkg::REG_HOLD, $urandom());
          set_reg(dclk_pkg::REG_REPEAT, $urandom());
          set_reg(REG_UNUSED, $urandom());
        end
        default: begin
          // short intervals so presses, holds and repeats happen often
          set_reg(dclk_pkg::REG_DEBOUNCE,
                  ($urandom() & 32'hFFFF_F000) | $urandom_range(0, 4));
          set_reg(dclk_pkg::REG_HOLD,
                  ($urandom() & 32'hFFFF_F000) | $urandom_range(0, 12));
          set_reg(dclk_pkg::REG_REPEAT,
                  ($urandom() & 32'hFFFF_F000) | $urandom_range(0, 6));
        end
      endcase
      check_registers();
      random_traffic(80);
      poll.valid <= 1'b0;
      wait_drained();
    end

    // last part, no idling: every interval at its maximum, random traffic
    // back to back on both sides
    idle_on = 1'b0;
    set_reg(dclk_pkg::REG_DEBOUNCE, 32'hFFFF_FFFF);
    set_reg(dclk_pkg::REG_HOLD, 32'hFFFF_FFFF);
    set_reg(dclk_pkg::REG_REPEAT, 32'hFFFF_FFFF);
    check_registers();
    random_traffic(60);
    poll.valid <= 1'b0;
    wait_drained();
    // allow for anything extra coming out of the pipeline
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog, several times the slowest correct run
  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- digital_clock_with_button_setup.f -----
+incdir+hdl
hdl/dclk_pkg.sv
hdl/dclk_poll_if.sv
hdl/dclk_status_if.sv
hdl/dclk_front.sv
hdl/dclk_queue.sv
hdl/dclk_back.sv
hdl/digital_clock_with_button_setup.sv
test/testbench.sv
